### rtl/hlkc_pkg.sv
// constants and types shared by the hashed lru key cache
package hlkc_pkg;

   localparam int SETS          = 64;
   localparam int WAYS          = 8;
   localparam int MAX_KEY_BYTES = 32;

   localparam int SET_W  = $clog2(SETS);
   localparam int WAY_W  = $clog2(WAYS);
   localparam int KPOS_W = $clog2(MAX_KEY_BYTES);
   localparam int KLEN_W = $clog2(MAX_KEY_BYTES + 1);
   localparam int OCC_W  = $clog2(WAYS + 1);
   localparam int SLOT_W = SET_W + WAY_W;
   localparam int BYTE_W = SLOT_W + KPOS_W;

   localparam logic [63:0] HASH_SEED = 64'd5381;

   typedef logic [SET_W-1:0]  set_type;
   typedef logic [WAY_W-1:0]  way_type;
   typedef logic [KLEN_W-1:0] klen_type;
   typedef logic [OCC_W-1:0]  occ_type;

endpackage

### rtl/hashed_lru_key_cache.sv
// hashed lru key cache: key gathering, set lookup, lru update and result register
//
// Usage: key bytes arrive on the req_ channel, one byte per word, with
// req_last_byte marking the final byte. Zero bytes and bytes past
// MAX_KEY_BYTES are dropped. A word without the last mark is taken whenever
// the block is idle. A word with the last mark starts a lookup in the selected
// set; its result leaves on the rsp_ channel.
// After the last word the block reads the set and its occupancy, walks the
// ways in recency order, reading each way's length and comparing the key
// bytes where the lengths agree, decides, shifts the recency entries on a hit
// or an eviction, writes the key on a miss and registers the result. The walk
// over the key memory, one byte per cycle through a single read port, is the
// slowest part. One lookup is in flight at a time; req_ready stays low until
// it finishes and the block is back in idle.
// At reset the counters clear, the hash returns to 5381 and a clearing pass
// over all SETS sets zeroes the set occupancy with req_ready low.
// When the receiver stalls, the result is held in rsp_ registers and the
// block still gathers the next key; a new lookup waits for the slot to drain.
module hashed_lru_key_cache
   import hlkc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_key_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic        rsp_evicted,
   output logic [5:0]  rsp_set_index,
   output logic [2:0]  rsp_way_index,
   output logic [31:0] rsp_access_count,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_eviction_count
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MOD    = 4'd1;
   localparam logic [3:0] ST_RDORD  = 4'd2;
   localparam logic [3:0] ST_RDLEN  = 4'd3;
   localparam logic [3:0] ST_CHKLEN = 4'd4;
   localparam logic [3:0] ST_CMP    = 4'd5;
   localparam logic [3:0] ST_DECIDE = 4'd6;
   localparam logic [3:0] ST_PROM   = 4'd7;
   localparam logic [3:0] ST_WRKEY  = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;
   localparam logic [3:0] ST_RDOCC  = 4'd10;
   localparam logic [3:0] ST_CLEAR  = 4'd11;

   // memories
   logic [7:0]        key_mem [MAX_KEY_BYTES];
   logic [7:0]        store_mem [SETS*WAYS*MAX_KEY_BYTES];
   logic [KLEN_W-1:0] len_mem [SETS*WAYS];
   logic [WAY_W-1:0]  ord_mem [SETS*WAYS];
   occ_type           occ_mem [SETS];

   logic [3:0]  state_ff, state_in;
   logic [63:0] hash_ff;
   klen_type    klen_ff;
   set_type     set_ff;
   set_type     clr_ff;
   occ_type     occ_cur_ff;
   logic [WAY_W:0] pos_ff;
   way_type     way_ff;
   klen_type    bpos_ff;
   logic        hit_ff, evict_ff;
   logic [31:0] acc_ff, hits_ff, ev_ff;
   logic [WAY_W:0] prom_from_ff;
   way_type     prom_way_ff;

   logic [7:0]        kbuf_rd, store_rd;
   logic [KLEN_W-1:0] len_rd;
   logic [WAY_W-1:0]  ord_rd;
   occ_type           occ_rd;

   logic take, keep, start, rsp_free;
   assign rsp_free = !rsp_valid || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!req_last_byte || rsp_free);
   assign take  = req_valid && req_ready;
   assign keep  = take && (req_key_byte != 8'd0) && (klen_ff < klen_type'(MAX_KEY_BYTES));
   assign start = take && req_last_byte;

   // next hash including the current word
   logic [63:0] hash_nx;
   assign hash_nx = keep ? ((hash_ff << 5) + hash_ff + {56'd0, req_key_byte}) : hash_ff;

   // memory addresses driven from state
   logic [SLOT_W-1:0] slot_cur;
   assign slot_cur = {set_ff, way_ff};

   // key buffer: written on gather, read during compare and key write
   always_ff @(posedge clock) begin
      if (keep) key_mem[klen_ff[KPOS_W-1:0]] <= req_key_byte;
      kbuf_rd <= key_mem[bpos_ff[KPOS_W-1:0]];
   end

   // stored key bytes
   logic st_we;
   assign st_we = (state_ff == ST_WRKEY) && (bpos_ff != 0);
   klen_type bprev;
   assign bprev = bpos_ff - klen_type'(1);
   always_ff @(posedge clock) begin
      if (st_we) store_mem[{slot_cur, bprev[KPOS_W-1:0]}] <= kbuf_rd;
      store_rd <= store_mem[{slot_cur, bpos_ff[KPOS_W-1:0]}];
   end

   // stored lengths: read at the way just fetched, written with the key
   logic len_we;
   logic [SLOT_W-1:0] len_ra;
   assign len_we = (state_ff == ST_WRKEY) && (bpos_ff == 0);
   assign len_ra = (state_ff == ST_RDLEN) ? {set_ff, ord_rd} : slot_cur;
   always_ff @(posedge clock) begin
      if (len_we) len_mem[slot_cur] <= klen_ff;
      len_rd <= len_mem[len_ra];
   end

   // recency order: read at pos, written during promote / insert
   logic             ord_we;
   logic [SLOT_W-1:0] ord_wa, ord_ra;
   way_type          ord_wd;
   logic [WAY_W:0]   pos_p1;
   assign pos_p1 = pos_ff + 1'b1;
   always_ff @(posedge clock) begin
      if (ord_we) ord_mem[ord_wa] <= ord_wd;
      ord_rd <= ord_mem[ord_ra];
   end

   // control
   always_comb begin
      state_in = state_ff;
      ord_we = 1'b0;
      ord_wa = {set_ff, pos_ff[WAY_W-1:0]};
      ord_wd = ord_rd;
      ord_ra = {set_ff, pos_ff[WAY_W-1:0]};
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == set_type'(SETS - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (start) state_in = ST_MOD;
         ST_MOD:    state_in = ST_RDOCC;
         ST_RDOCC:  state_in = ST_RDORD;
         ST_RDORD:  state_in = (pos_ff < occ_cur_ff) ? ST_RDLEN : ST_DECIDE;
         ST_RDLEN:  state_in = ST_CHKLEN;
         ST_CHKLEN: state_in = (len_rd == klen_ff) ? ST_CMP : ST_RDORD;
         ST_CMP: begin
            if (bpos_ff == klen_ff && (bpos_ff == 0 || store_rd == kbuf_rd))
               state_in = ST_DECIDE;
            else if (bpos_ff != 0 && store_rd != kbuf_rd)
               state_in = ST_RDORD;
         end
         ST_DECIDE: begin
            if (hit_ff || evict_ff) begin
               // fetch the entry that moves down first
               ord_ra = {set_ff, pos_p1[WAY_W-1:0]};
               state_in = ST_PROM;
            end else begin
               ord_we = 1'b1;
               ord_wa = {set_ff, occ_cur_ff[WAY_W-1:0]};
               ord_wd = occ_cur_ff[WAY_W-1:0];
               state_in = ST_WRKEY;
            end
         end
         ST_PROM: begin
            // shift one entry down per cycle, read next ahead
            ord_ra = {set_ff, pos_p1[WAY_W-1:0]};
            if (pos_ff == prom_from_ff) begin
               state_in = ST_PROM;
            end else begin
               ord_we = 1'b1;
               ord_wa = {set_ff, pos_ff[WAY_W-1:0] - 1'b1};
               ord_wd = ord_rd;
            end
            if (pos_ff == WAY_W'(0) + occ_cur_ff) begin
               ord_we = 1'b1;
               ord_wa = {set_ff, pos_ff[WAY_W-1:0] - 1'b1};
               ord_wd = prom_way_ff;
               state_in = hit_ff ? ST_DONE : ST_WRKEY;
            end
         end
         ST_WRKEY:  if (bpos_ff == klen_ff) state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   logic [63:0] mag_c;
   set_type     set_c;
   assign mag_c = hash_ff[63] ? (64'd0 - hash_ff) : hash_ff;
   assign set_c = set_type'(mag_c % SETS);

   // set occupancy: cleared after reset, read at the selected set
   logic    occ_we;
   set_type occ_wa, occ_ra;
   occ_type occ_wd;
   assign occ_we = (state_ff == ST_CLEAR) ||
                   ((state_ff == ST_DECIDE) && !hit_ff && !evict_ff);
   assign occ_wa = (state_ff == ST_CLEAR) ? clr_ff : set_ff;
   assign occ_wd = (state_ff == ST_CLEAR) ? '0 : occ_cur_ff + occ_type'(1);
   assign occ_ra = (state_ff == ST_MOD) ? set_c : set_ff;
   always_ff @(posedge clock) begin
      if (occ_we) occ_mem[occ_wa] <= occ_wd;
      occ_rd <= occ_mem[occ_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         hash_ff   <= HASH_SEED;
         klen_ff   <= '0;
         acc_ff    <= '0;
         hits_ff   <= '0;
         ev_ff     <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + set_type'(1);
            end
            ST_IDLE: begin
               hash_ff <= hash_nx;
               if (keep) klen_ff <= klen_ff + klen_type'(1);
            end
            ST_MOD: begin
               set_ff     <= set_c;
               pos_ff     <= '0;
               hit_ff     <= 1'b0;
               evict_ff   <= 1'b0;
            end
            ST_RDOCC: begin
               occ_cur_ff <= occ_rd;
            end
            ST_RDORD: begin
               // ord_rd for pos_ff is fetched here and used in ST_RDLEN
               if (pos_ff >= occ_cur_ff) begin
                  if (occ_cur_ff == occ_type'(WAYS)) begin
                     evict_ff     <= 1'b1;
                     prom_from_ff <= '0;
                  end
               end
            end
            ST_RDLEN: begin
               way_ff  <= ord_rd;
            end
            ST_CHKLEN: begin
               bpos_ff <= '0;
               if (len_rd != klen_ff) pos_ff <= pos_p1;
            end
            ST_CMP: begin
               if (bpos_ff == klen_ff && (bpos_ff == 0 || store_rd == kbuf_rd)) begin
                  hit_ff       <= 1'b1;
                  prom_from_ff <= pos_ff;
                  prom_way_ff  <= way_ff;
               end else if (bpos_ff != 0 && store_rd != kbuf_rd) begin
                  pos_ff <= pos_p1;
               end else begin
                  bpos_ff <= bpos_ff + klen_type'(1);
               end
            end
            ST_DECIDE: begin
               bpos_ff <= '0;
               if (hit_ff) begin
                  pos_ff <= prom_from_ff + 1'b1;
               end else if (evict_ff) begin
                  way_ff      <= ord_rd;
                  prom_way_ff <= ord_rd;
                  pos_ff      <= (WAY_W+1)'(1);
               end else begin
                  way_ff <= occ_cur_ff[WAY_W-1:0];
               end
            end
            ST_PROM: begin
               pos_ff <= pos_p1;
               if (!hit_ff) bpos_ff <= '0;
            end
            ST_WRKEY: begin
               if (bpos_ff != klen_ff) bpos_ff <= bpos_ff + klen_type'(1);
            end
            ST_DONE: begin
               rsp_valid          <= 1'b1;
               rsp_hit            <= hit_ff;
               rsp_evicted        <= evict_ff;
               rsp_set_index      <= 6'(set_ff);
               rsp_way_index      <= 3'(way_ff);
               rsp_access_count   <= acc_ff + 32'd1;
               rsp_hit_count      <= hits_ff + {31'd0, hit_ff};
               rsp_eviction_count <= ev_ff + {31'd0, evict_ff};
               acc_ff  <= acc_ff + 32'd1;
               hits_ff <= hits_ff + {31'd0, hit_ff};
               ev_ff   <= ev_ff + {31'd0, evict_ff};
               hash_ff <= HASH_SEED;
               klen_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // a hit and an eviction never come together
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("hit and eviction together");
   // the result registers are never rewritten while a result waits unaccepted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(state_ff == ST_DONE))
      else $error("result overwritten");
   // the key length never exceeds the buffer
   assert property (@(posedge clock) disable iff (reset) klen_ff <= klen_type'(MAX_KEY_BYTES))
      else $error("key length overflow");

endmodule
